// ===== sv/ddo_pkg.sv =====
`default_nettype none

package ddo_pkg;

	// Upper bound on CORDIC iterations; the arctangent table holds this many entries
	localparam int unsigned MAX_STEPS = 24;

	// CORDIC start value, gain 0.6072529350 in Q2.30
	localparam logic signed [33:0] CORDIC_K = 34'sd652032874;

	// atan(2^-i) on a 32-bit circle (2^32 is a full turn)
	localparam logic [31:0] ATAN_TAB [MAX_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	// Vector and residual angle moving down the CORDIC chain
	typedef struct packed {
		logic              vld;
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [32:0] z;
	} cell_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_TURN,
		ST_RUN,
		ST_PROD,
		ST_UPD
	} state_t;

endpackage

`default_nettype wire

// ===== sv/differential_drive_odometry_core.sv =====
// Dead-reckoning pose tracker for a two-wheel robot.
// Input channel (in_valid/in_ready): op 0 brings wheel deltas, op 1 loads x, y and heading.
// Each accepted item yields exactly one result item on the output channel
// (out_valid/out_ready): pose and wheel totals after that item.
// Config channel (cfg_valid/cfg_ready/cfg_data) writes heading_gain; it is always ready
// and should only be written while no item is in flight.
// An update passes through the states MUL, TURN, RUN (while it walks the row of CORDIC
// cells), PROD and UPD before out_valid is raised; a load passes through MUL and UPD. One
// item is in flight at a time, so a new item is not taken until the last one is committed.
// The result sits in an output register: in_ready returns while it waits, and the next
// item's result is held back inside until that register is taken.
// Reset (arst_n low) clears pose, wheel totals and gain to zero and empties the block.
`default_nettype none

module differential_drive_odometry_core #(
	parameter int unsigned CORDIC_STEPS = 16,
	parameter int unsigned ANGLE_BITS   = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [23:0]        cfg_data,
	// input items
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               op,
	input  wire logic signed [15:0] delta_left,
	input  wire logic signed [15:0] delta_right,
	input  wire logic signed [31:0] pose_x,
	input  wire logic signed [31:0] pose_y,
	input  wire logic [15:0]        pose_heading,
	// result items
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      x,
	output logic signed [31:0]      y,
	output logic [15:0]             heading,
	output logic signed [39:0]      left_total,
	output logic signed [39:0]      right_total
);

	localparam int unsigned NSTEP = (CORDIC_STEPS > ddo_pkg::MAX_STEPS) ?
		ddo_pkg::MAX_STEPS : CORDIC_STEPS;
	localparam int unsigned SH = 32 - ANGLE_BITS;

	// control
	ddo_pkg::state_t state_q, state_nxt;
	logic            launch, run_done, commit;

	// config
	logic [23:0] gain_q;

	// captured item
	logic                  op_q;
	logic signed [15:0]    dl_q, dr_q;
	logic signed [31:0]    px_q, py_q;
	logic [15:0]           ph_q;

	// architectural state
	logic signed [31:0]     pos_x_q, pos_y_q;
	logic [ANGLE_BITS-1:0]  head_q;
	logic signed [39:0]     lsum_q, rsum_q;

	// datapath
	logic signed [41:0]     dturn_q;
	logic signed [16:0]     sum_q;
	logic [ANGLE_BITS-1:0]  second_q;
	logic                   flip_q;
	logic signed [16:0]     cos_q, sin_q;
	logic signed [33:0]     prod_x_q, prod_y_q;

	// output register
	logic                   out_valid_q;
	logic signed [31:0]     out_x_q, out_y_q;
	logic [15:0]            out_h_q;
	logic signed [39:0]     out_l_q, out_r_q;

	logic signed [42:0]     rnd_half, rnd_whole;
	logic [ANGLE_BITS-1:0]  first_ang, whole_ang, head_turn, head_load;
	logic [31:0]            ang32, ang_fold;
	logic                   fold;
	logic signed [16:0]     cos_v, sin_v;
	logic signed [34:0]     step_x, step_y;

	ddo_pkg::cell_t chain [NSTEP+1];

	// Q2.30 to Q1.15, round half up, saturate
	function automatic logic signed [15:0] q15_sat(input logic signed [33:0] v);
		logic signed [34:0] t;
		logic signed [19:0] r;
		t = 35'(v) + 35'sd16384;
		r = 20'(t >>> 15);
		if (r > 20'sd32767) begin
			q15_sat = 16'sh7FFF;
		end else if (r < -20'sd32768) begin
			q15_sat = 16'sh8000;
		end else begin
			q15_sat = 16'(r);
		end
	endfunction

	// heading output for a value not yet in head_q
	function automatic logic [15:0] head_out_after(input logic [ANGLE_BITS-1:0] h);
		logic [31:0] w;
		w = {h, {SH{1'b0}}};
		head_out_after = w[31:16];
	endfunction

	assign cfg_ready = 1'b1;

	// sequencer: state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ddo_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// sequencer: next state and strobes
	always_comb begin
		state_nxt = state_q;
		in_ready  = 1'b0;
		launch    = 1'b0;
		run_done  = 1'b0;
		commit    = 1'b0;
		case (state_q)
			ddo_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_nxt = ddo_pkg::ST_MUL;
				end
			end
			ddo_pkg::ST_MUL: begin
				state_nxt = op_q ? ddo_pkg::ST_UPD : ddo_pkg::ST_TURN;
			end
			ddo_pkg::ST_TURN: begin
				launch    = 1'b1;
				state_nxt = ddo_pkg::ST_RUN;
			end
			ddo_pkg::ST_RUN: begin
				if (chain[NSTEP].vld) begin
					run_done  = 1'b1;
					state_nxt = ddo_pkg::ST_PROD;
				end
			end
			ddo_pkg::ST_PROD: begin
				state_nxt = ddo_pkg::ST_UPD;
			end
			ddo_pkg::ST_UPD: begin
				if (!out_valid_q || out_ready) begin
					commit    = 1'b1;
					state_nxt = ddo_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = ddo_pkg::ST_IDLE;
			end
		endcase
	end

	// heading split: first half rounded half up, second half is the rest
	assign rnd_half  = 43'(dturn_q) + (43'sd1 <<< SH);
	assign rnd_whole = 43'(dturn_q) + (43'sd1 <<< (SH - 1));
	assign first_ang = ANGLE_BITS'(rnd_half >>> (SH + 1));
	assign whole_ang = ANGLE_BITS'(rnd_whole >>> SH);
	assign head_turn = head_q + first_ang;

	// fold left half plane onto the right half, remember to negate
	assign ang32    = {head_turn, {SH{1'b0}}};
	assign fold     = ang32[31] ^ ang32[30];
	assign ang_fold = {ang32[31] ^ fold, ang32[30:0]};

	// heading width conversion for a load
	generate
		if (ANGLE_BITS >= 16) begin : g_wide
			assign head_load = ANGLE_BITS'(ph_q) << (ANGLE_BITS - 16);
		end else begin : g_narrow
			assign head_load = ANGLE_BITS'(ph_q >> (16 - ANGLE_BITS));
		end
	endgenerate

	// CORDIC row
	always_comb begin
		chain[0].vld = launch;
		chain[0].x   = ddo_pkg::CORDIC_K;
		chain[0].y   = '0;
		chain[0].z   = {ang_fold[31], ang_fold};
	end

	generate
		for (genvar i = 0; i < NSTEP; i++) begin : g_cell
			ddo_cell #(
				.STEP(i)
			) u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.d_in  (chain[i]),
				.d_out (chain[i+1])
			);
		end
	endgenerate

	// rounded cosine and sine, sign restored
	always_comb begin
		cos_v = 17'(q15_sat(chain[NSTEP].x));
		sin_v = 17'(q15_sat(chain[NSTEP].y));
		if (flip_q) begin
			cos_v = -cos_v;
			sin_v = -sin_v;
		end
	end

	// position steps, round half up after /2^16
	assign step_x = (35'(prod_x_q) + 35'sd32768) >>> 16;
	assign step_y = (35'(prod_y_q) + 35'sd32768) >>> 16;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= '0;
		end else if (cfg_valid) begin
			gain_q <= cfg_data;
		end
	end

	// item capture and arithmetic pipeline
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q <= op;
			dl_q <= delta_left;
			dr_q <= delta_right;
			px_q <= pose_x;
			py_q <= pose_y;
			ph_q <= pose_heading;
		end
		if (state_q == ddo_pkg::ST_MUL) begin
			dturn_q <= 42'((17'(dr_q) - 17'(dl_q)) * $signed({1'b0, gain_q}));
			sum_q   <= 17'(dl_q) + 17'(dr_q);
		end
		if (launch) begin
			second_q <= whole_ang - first_ang;
			flip_q   <= fold;
		end
		if (run_done) begin
			cos_q <= cos_v;
			sin_q <= sin_v;
		end
		if (state_q == ddo_pkg::ST_PROD) begin
			prod_x_q <= sum_q * cos_q;
			prod_y_q <= sum_q * sin_q;
		end
	end

	// pose and wheel totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			head_q  <= '0;
			lsum_q  <= '0;
			rsum_q  <= '0;
		end else begin
			if (launch) begin
				head_q <= head_turn;
				lsum_q <= lsum_q + 40'(dl_q);
				rsum_q <= rsum_q + 40'(dr_q);
			end
			if (commit) begin
				if (op_q) begin
					pos_x_q <= px_q;
					pos_y_q <= py_q;
					head_q  <= head_load;
				end else begin
					pos_x_q <= pos_x_q + 32'(step_x);
					pos_y_q <= pos_y_q + 32'(step_y);
					head_q  <= head_q + second_q;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_l_q <= lsum_q;
			out_r_q <= rsum_q;
			if (op_q) begin
				out_x_q <= px_q;
				out_y_q <= py_q;
				out_h_q <= (ANGLE_BITS >= 16) ? ph_q : (ph_q & ~16'((17'd1 << SH - 16) - 17'd1));
			end else begin
				out_x_q <= pos_x_q + 32'(step_x);
				out_y_q <= pos_y_q + 32'(step_y);
				out_h_q <= 16'(head_out_after(head_q + second_q));
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign x           = out_x_q;
	assign y           = out_y_q;
	assign heading     = out_h_q;
	assign left_total  = out_l_q;
	assign right_total = out_r_q;

endmodule

`default_nettype wire

// ===== sv/ddo_cell.sv =====
`default_nettype none

// One CORDIC rotation step with its own register
module ddo_cell #(
	parameter int unsigned STEP = 0
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire ddo_pkg::cell_t d_in,
	output ddo_pkg::cell_t      d_out
);

	logic signed [32:0] atan_v;
	ddo_pkg::cell_t     nxt;

	logic               vld_q;
	logic signed [33:0] x_q;
	logic signed [33:0] y_q;
	logic signed [32:0] z_q;

	assign atan_v = $signed(33'(ddo_pkg::ATAN_TAB[STEP]));

	// rotate toward zero residual angle
	always_comb begin
		nxt = d_in;
		if (!d_in.z[32]) begin
			nxt.x = d_in.x - (d_in.y >>> STEP);
			nxt.y = d_in.y + (d_in.x >>> STEP);
			nxt.z = d_in.z - atan_v;
		end else begin
			nxt.x = d_in.x + (d_in.y >>> STEP);
			nxt.y = d_in.y - (d_in.x >>> STEP);
			nxt.z = d_in.z + atan_v;
		end
	end

	// valid resets, data just follows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= d_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		x_q <= nxt.x;
		y_q <= nxt.y;
		z_q <= nxt.z;
	end

	assign d_out.vld = vld_q;
	assign d_out.x   = x_q;
	assign d_out.y   = y_q;
	assign d_out.z   = z_q;

endmodule

`default_nettype wire

// ===== sv/ddo_checker.sv =====
`default_nettype none

// Port-level checks for the odometry core
module ddo_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               op,
	input wire logic signed [31:0] pose_x,
	input wire logic signed [31:0] pose_y,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic signed [31:0] x,
	input wire logic signed [31:0] y,
	input wire logic [15:0]        heading,
	input wire logic signed [39:0] left_total,
	input wire logic signed [39:0] right_total
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(x) && $stable(y) &&
			$stable(heading) && $stable(left_total) && $stable(right_total))
		else $error("stalled result changed");

	// one item in flight: input closes right after an item is taken
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item accepted while busy");

	// a result only appears at the end of an item's work
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without an item");

	// a pose load into a free output is delivered with the loaded position
	a_load_pose: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && op && !out_valid |-> ##3
			(out_valid && x == $past(pose_x, 3) && y == $past(pose_y, 3)))
		else $error("loaded pose not delivered");

endmodule

bind differential_drive_odometry_core ddo_checker u_ddo_checker (.*);

`default_nettype wire

// ===== verif/tb_differential_drive_odometry_core.sv =====
`timescale 1ns / 1ps

// op codes of an input item
typedef enum logic {
	OP_UPDATE = 1'b0,
	OP_LOAD   = 1'b1
} odo_op_t;

typedef struct {
	odo_op_t            op;
	logic signed [15:0] dl;
	logic signed [15:0] dr;
	logic signed [31:0] px;
	logic signed [31:0] py;
	logic [15:0]        ph;
} odo_item_t;

typedef struct {
	logic signed [31:0] x;
	logic signed [31:0] y;
	logic [15:0]        heading;
	logic signed [39:0] left_total;
	logic signed [39:0] right_total;
} odo_pose_t;

// arctangent of 2^-i on a 32-bit circle
localparam longint ODO_ATAN [24] = '{
	64'sh20000000, 64'sh12E4051E, 64'sh09FB385B, 64'sh051111D4, 64'sh028B0D43, 64'sh0145D7E1,
	64'sh00A2F61E, 64'sh00517C55, 64'sh0028BE53, 64'sh00145F2F, 64'sh000A2F98, 64'sh000517CC,
	64'sh00028BE6, 64'sh000145F3, 64'sh0000A2FA, 64'sh0000517D, 64'sh000028BE, 64'sh0000145F,
	64'sh00000A30, 64'sh00000518, 64'sh0000028C, 64'sh00000146, 64'sh000000A3, 64'sh00000051
};
localparam longint ODO_CORDIC_START = 64'sd652032874;
localparam longint ODO_QUARTER      = 64'sh40000000;
localparam longint ODO_HALF         = 64'sh80000000;
localparam longint ODO_THREE_Q      = 64'shC0000000;
localparam longint ODO_FULL         = 64'sh100000000;
localparam longint ODO_M32          = 64'shFFFFFFFF;

// Pose tracker mirror plus the queue of poses still owed by the block
class odo_scoreboard #(int unsigned STEPS = 16, int unsigned ABITS = 16);
	int unsigned        errors;
	int unsigned        results_seen;
	bit [23:0]          gain;
	bit signed [31:0]   px;
	bit signed [31:0]   py;
	bit [ABITS-1:0]     ang;
	bit signed [39:0]   lsum;
	bit signed [39:0]   rsum;
	odo_pose_t          pose_queue[$];

	function new();
		errors = 0;
		results_seen = 0;
		gain = '0;
		px = '0;
		py = '0;
		ang = '0;
		lsum = '0;
		rsum = '0;
	endfunction

	function void set_gain(bit [23:0] g);
		gain = g;
	endfunction

	function int pending();
		return pose_queue.size();
	endfunction

	// Q1.15 with round half up, saturated
	function longint round_q15(longint v);
		longint r;
		r = (v + 64'sd16384) >>> 15;
		if (r > 32767)
			r = 32767;
		if (r < -32768)
			r = -32768;
		return r;
	endfunction

	// rotation-mode CORDIC; left half plane is folded over and negated afterwards
	function void cordic_trig(input bit [ABITS-1:0] a_in, output longint c, output longint s);
		longint a, z, xv, yv, nx;
		bit flip;
		int n;
		a = (longint'(a_in) << (32 - ABITS)) & ODO_M32;
		flip = 1'b0;
		if (a >= ODO_QUARTER && a < ODO_THREE_Q) begin
			a = (a - ODO_HALF) & ODO_M32;
			flip = 1'b1;
		end
		z = (a >= ODO_HALF) ? a - ODO_FULL : a;
		xv = ODO_CORDIC_START;
		yv = 0;
		n = (STEPS > 24) ? 24 : int'(STEPS);
		for (int i = 0; i < n; i++) begin
			if (z >= 0) begin
				nx = xv - (yv >>> i);
				yv = yv + (xv >>> i);
				z = z - ODO_ATAN[i];
			end else begin
				nx = xv + (yv >>> i);
				yv = yv - (xv >>> i);
				z = z + ODO_ATAN[i];
			end
			xv = nx;
		end
		c = round_q15(xv);
		s = round_q15(yv);
		if (flip) begin
			c = -c;
			s = -s;
		end
	endfunction

	function bit [15:0] heading16();
		if (ABITS >= 16)
			return 16'(longint'(ang) >> (ABITS - 16));
		else
			return 16'(longint'(ang) << (16 - ABITS));
	endfunction

	// advance the pose by one accepted item and queue the pose it should produce
	function void advance_pose(odo_item_t it);
		longint dl, dr, d, first, whole, sum, c, s;
		int sh;
		odo_pose_t p;
		if (it.op == OP_LOAD) begin
			px = it.px;
			py = it.py;
			if (ABITS >= 16)
				ang = ABITS'(longint'(it.ph) << (ABITS - 16));
			else
				ang = ABITS'(longint'(it.ph) >> (16 - ABITS));
		end else begin
			dl = longint'(it.dl);
			dr = longint'(it.dr);
			d = (dr - dl) * longint'(gain);
			sh = 32 - int'(ABITS);
			first = (d + (longint'(1) << sh)) >>> (sh + 1);
			whole = (d + (longint'(1) << (sh - 1))) >>> sh;
			sum = dl + dr;
			lsum = 40'(longint'(lsum) + dl);
			rsum = 40'(longint'(rsum) + dr);
			// half the turn, move along the mid heading, then the rest of the turn
			ang = ABITS'(longint'(ang) + first);
			cordic_trig(ang, c, s);
			px = 32'(longint'(px) + ((sum * c + 64'sd32768) >>> 16));
			py = 32'(longint'(py) + ((sum * s + 64'sd32768) >>> 16));
			ang = ABITS'(longint'(ang) + (whole - first));
		end
		p.x = px;
		p.y = py;
		p.heading = heading16();
		p.left_total = lsum;
		p.right_total = rsum;
		pose_queue.push_back(p);
	endfunction

	task report(string what);
		errors++;
		if (errors <= 40)
			$display("ERROR result %0d: %s", results_seen, what);
	endtask

	task check_result(odo_pose_t got);
		odo_pose_t want;
		if (pose_queue.size() == 0) begin
			report("result item with no input item outstanding");
		end else begin
			want = pose_queue.pop_front();
			if (got.x !== want.x)
				report($sformatf("x got %0d want %0d", got.x, want.x));
			if (got.y !== want.y)
				report($sformatf("y got %0d want %0d", got.y, want.y));
			if (got.heading !== want.heading)
				report($sformatf("heading got %0d want %0d", got.heading, want.heading));
			if (got.left_total !== want.left_total)
				report($sformatf("left_total got %0d want %0d",
					got.left_total, want.left_total));
			if (got.right_total !== want.right_total)
				report($sformatf("right_total got %0d want %0d",
					got.right_total, want.right_total));
		end
		results_seen++;
	endtask
endclass

module tb_differential_drive_odometry_core;

	localparam int unsigned CORDIC_STEPS = 16;
	localparam int unsigned ANGLE_BITS   = 16;
	localparam int QUIET_LIMIT = 2000;
	localparam int LONG_HOLD   = 300;
	localparam int PHASE_ITEMS = 100;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [23:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               op = 1'b0;
	logic signed [15:0] delta_left = '0;
	logic signed [15:0] delta_right = '0;
	logic signed [31:0] pose_x = '0;
	logic signed [31:0] pose_y = '0;
	logic [15:0]        pose_heading = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] x;
	logic signed [31:0] y;
	logic [15:0]        heading;
	logic signed [39:0] left_total;
	logic signed [39:0] right_total;

	odo_scoreboard #(CORDIC_STEPS, ANGLE_BITS) sb;

	bit burst = 1'b0;
	bit hold_outputs = 1'b0;
	int quiet_cycles = 0;

	differential_drive_odometry_core #(
		.CORDIC_STEPS(CORDIC_STEPS),
		.ANGLE_BITS  (ANGLE_BITS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.delta_left  (delta_left),
		.delta_right (delta_right),
		.pose_x      (pose_x),
		.pose_y      (pose_y),
		.pose_heading(pose_heading),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.x           (x),
		.y           (y),
		.heading     (heading),
		.left_total  (left_total),
		.right_total (right_total)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// watch all three channels at each edge
	always @(posedge clk) begin : monitor
		odo_item_t it;
		odo_pose_t res;
		bit moved;
		if (arst_n) begin
			moved = 1'b0;
			if (cfg_valid && cfg_ready) begin
				sb.set_gain(cfg_data);
				moved = 1'b1;
			end
			if (in_valid && in_ready) begin
				it.op = odo_op_t'(op);
				it.dl = delta_left;
				it.dr = delta_right;
				it.px = pose_x;
				it.py = pose_y;
				it.ph = pose_heading;
				sb.advance_pose(it);
				moved = 1'b1;
			end
			if (out_valid && out_ready) begin
				res.x = x;
				res.y = y;
				res.heading = heading;
				res.left_total = left_total;
				res.right_total = right_total;
				sb.check_result(res);
				moved = 1'b1;
			end
			// watchdog: too long without any handshake
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout after %0d quiet cycles", quiet_cycles);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// result side: random ready pattern, plus one long hold on request
	initial begin : receiver
		int r;
		int n;
		forever begin
			if (hold_outputs) begin
				hold_outputs = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					out_ready <= 1'b1;
					n = $urandom_range(1, 24);
				end else if (r < 90) begin
					out_ready <= 1'b0;
					n = $urandom_range(1, 3);
				end else begin
					out_ready <= 1'b0;
					n = $urandom_range(8, 40);
				end
				repeat (n) @(posedge clk);
			end
		end
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (burst || r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 96)
			return $urandom_range(4, 12);
		else
			return $urandom_range(25, 60);
	endfunction

	function automatic logic signed [15:0] pick_delta();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15) begin
			case ($urandom_range(0, 4))
				0: return -16'sd32768;
				1: return 16'sd32767;
				2: return 16'sd0;
				3: return -16'sd1;
				default: return 16'sd1;
			endcase
		end else if (r < 55) begin
			return 16'(int'($urandom_range(0, 400)) - 200);
		end else begin
			return 16'($urandom);
		end
	endfunction

	function automatic odo_item_t update_item(int dl, int dr);
		odo_item_t it;
		it.op = OP_UPDATE;
		it.dl = 16'(dl);
		it.dr = 16'(dr);
		it.px = 32'($urandom);
		it.py = 32'($urandom);
		it.ph = 16'($urandom);
		return it;
	endfunction

	function automatic odo_item_t load_item(logic [31:0] lx, logic [31:0] ly, logic [15:0] lh);
		odo_item_t it;
		it.op = OP_LOAD;
		it.dl = 16'($urandom);
		it.dr = 16'($urandom);
		it.px = lx;
		it.py = ly;
		it.ph = lh;
		return it;
	endfunction

	// straight runs and spins mixed with arbitrary deltas, some pose loads
	function automatic odo_item_t random_item();
		odo_item_t it;
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return load_item($urandom, $urandom, 16'($urandom));
		it = update_item(0, 0);
		it.dl = pick_delta();
		if (r < 25)
			it.dr = it.dl;
		else if (r < 35)
			it.dr = -it.dl;
		else
			it.dr = pick_delta();
		return it;
	endfunction

	// present one item, hold it until taken, then maybe go idle
	task automatic send_item(input odo_item_t it);
		int gap;
		in_valid <= 1'b1;
		op <= it.op;
		delta_left <= it.dl;
		delta_right <= it.dr;
		pose_x <= it.px;
		pose_y <= it.py;
		pose_heading <= it.ph;
		do @(posedge clk); while (!in_ready);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// gain is only changed with the block empty
	task automatic write_gain(input logic [23:0] g);
		drain();
		repeat (CORDIC_STEPS + 5) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= g;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		logic [23:0] phase_gain [5];
		sb = new();
		phase_gain[0] = 24'h000001;
		phase_gain[1] = 24'h000400;
		phase_gain[2] = 24'($urandom_range(0, 24'hFFFFFF));
		phase_gain[3] = 24'h010000;
		phase_gain[4] = 24'h800000;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no turning: quadrant edges of the heading and full-scale travel
		write_gain(24'h000000);
		send_item(load_item(32'h7FFFFFFF, 32'h80000000, 16'h4000));
		send_item(update_item(32767, 32767));
		send_item(update_item(-32768, -32768));
		send_item(load_item(32'h0, 32'h0, 16'hC000));
		send_item(update_item(32767, 32767));
		send_item(load_item(32'h0, 32'h0, 16'h8000));
		send_item(update_item(100, 100));
		send_item(load_item(32'h80000000, 32'h7FFFFFFF, 16'hFFFF));
		send_item(update_item(-32768, -32768));

		// largest gain: widest wheel differences, ties in the half turn
		write_gain(24'hFFFFFF);
		send_item(update_item(-32768, 32767));
		send_item(update_item(32767, -32768));
		send_item(update_item(0, 0));
		send_item(update_item(0, 1));
		send_item(update_item(1, 0));
		send_item(update_item(-1, -1));
		send_item(load_item(32'h0, 32'h0, 16'h3FFF));
		send_item(update_item(5, -5));

		// unit gain: quarter turn in one step
		write_gain(24'h010000);
		send_item(update_item(0, 16384));
		send_item(update_item(-32768, 32767));
		send_item(update_item(32767, 32767));
		send_item(load_item(32'hFFFFFFFF, 32'hFFFFFFFF, 16'h0000));
		send_item(update_item(-2, 1));

		// random phases, one gain each
		for (int p = 0; p < 5; p++) begin
			write_gain(phase_gain[p]);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				burst = (k < 30);
				// fill the block against a stalled output
				if (p == 1 && k == 5)
					hold_outputs = 1'b1;
				if (k == 60)
					drain();
				send_item(random_item());
			end
		end
		burst = 1'b0;

		drain();
		repeat (CORDIC_STEPS + 10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== files.f =====
sv/ddo_pkg.sv
sv/ddo_cell.sv
sv/differential_drive_odometry_core.sv
sv/ddo_checker.sv
verif/tb_differential_drive_odometry_core.sv
